### hdl/lsg_pkg.sv
`default_nettype none
package lsg_pkg;

   localparam int DIR_BITS     = 18;
   localparam int DIFF_BITS    = 19;
   localparam int CORDIC_STEPS = 15;
   localparam int DEG_90       = 23040;
   localparam int DEG_180      = 46080;
   localparam int DEG_360      = 92160;
   localparam int DIST_BITS    = 12;
   localparam int ANGLE_BITS   = 8;

   localparam logic REG_DISTANCE = 1'b0;
   localparam logic REG_ANGLE    = 1'b1;

   typedef logic signed [DIR_BITS-1:0] dir_type;

   function automatic dir_type atan_step(input logic [3:0] idx);
      dir_type v;
      case (idx)
         4'd0:    v = 18'sd11520;
         4'd1:    v = 18'sd6801;
         4'd2:    v = 18'sd3593;
         4'd3:    v = 18'sd1824;
         4'd4:    v = 18'sd916;
         4'd5:    v = 18'sd458;
         4'd6:    v = 18'sd229;
         4'd7:    v = 18'sd115;
         4'd8:    v = 18'sd57;
         4'd9:    v = 18'sd29;
         4'd10:   v = 18'sd14;
         4'd11:   v = 18'sd7;
         4'd12:   v = 18'sd4;
         4'd13:   v = 18'sd2;
         4'd14:   v = 18'sd1;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### hdl/lsg_cordic.sv
`default_nettype none
module lsg_cordic #(
   parameter int CB = 12
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire  signed [CB:0]            dx,
   input  wire  signed [CB:0]            dy,
   output logic                          busy,
   output lsg_pkg::dir_type              angle
);
   localparam int XW = CB + 11;

   logic                 busy_ff, busy_in;
   logic                 zero_ff, zero_in;
   logic [3:0]           step_ff, step_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   lsg_pkg::dir_type     z_ff, z_in;
   logic signed [XW-1:0] x0, y0, xs, ys;

   always_comb begin
      x0 = {{(XW-CB-9){dx[CB]}}, dx, 8'd0};
      y0 = {{(XW-CB-9){dy[CB]}}, dy, 8'd0};
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 4'd0;
         zero_in = (dx == '0) && (dy == '0);
         if (x0 < 0) begin
            if (y0 >= 0) begin
               x_in = y0;
               y_in = -x0;
               z_in = lsg_pkg::dir_type'(lsg_pkg::DEG_90);
            end else begin
               x_in = -y0;
               y_in = x0;
               z_in = -lsg_pkg::dir_type'(lsg_pkg::DEG_90);
            end
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (zero_ff) begin
            z_in    = '0;
            busy_in = 1'b0;
         end else begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + lsg_pkg::atan_step(step_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - lsg_pkg::atan_step(step_ff);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(lsg_pkg::CORDIC_STEPS - 1)) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      zero_ff <= zero_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign busy  = busy_ff;
   assign angle = z_ff;
endmodule
`default_nettype wire

### hdl/lsg_div.sv
`default_nettype none
module lsg_div #(
   parameter int NW = 22,
   parameter int DW = 11
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           start,
   input  wire  [NW-1:0] num,
   input  wire  [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

### hdl/lsg_fifo.sv
`default_nettype none
module lsg_fifo #(
   parameter int W = 67
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   input  wire [W-1:0]  push_data,
   output logic         full,
   input  wire          pop,
   output logic [W-1:0] head,
   output logic         empty
);
   logic [W-1:0] mem_ff [4];
   logic [1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]   cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rp_ff];
   assign full  = cnt_ff == 3'd4;
   assign empty = cnt_ff == 3'd0;
endmodule
`default_nettype wire

### hdl/lsg_front.sv
`default_nettype none
module lsg_front #(
   parameter int CB = 12
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [CB-1:0]         req_start_x,
   input  wire  [CB-1:0]         req_start_y,
   input  wire  [CB-1:0]         req_end_x,
   input  wire  [CB-1:0]         req_end_y,
   input  wire                   req_frame_last,
   output logic                  push,
   output logic [4*CB+lsg_pkg::DIR_BITS:0] push_data,
   input  wire                   full
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIR  = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [4*CB:0]     seg_ff, seg_in;
   logic              accept, cbusy;
   logic signed [CB:0] dx, dy;
   lsg_pkg::dir_type  angle;

   assign accept = req_valid && !req_stall;
   assign dx = $signed({1'b0, req_end_x}) - $signed({1'b0, req_start_x});
   assign dy = $signed({1'b0, req_end_y}) - $signed({1'b0, req_start_y});

   lsg_cordic #(.CB(CB)) u_cordic (
      .clock(clock), .reset(reset), .start(accept), .dx(dx), .dy(dy),
      .busy(cbusy), .angle(angle)
   );

   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      push     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               seg_in   = {req_start_x, req_start_y, req_end_x, req_end_y, req_frame_last};
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            if (!cbusy) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      seg_ff <= seg_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign push_data = {seg_ff, angle};
endmodule
`default_nettype wire

### hdl/lsg_back.sv
`default_nettype none
module lsg_back #(
   parameter int MAX_GROUPS = 16,
   parameter int MAX_LINES  = 1024,
   parameter int CB         = 12
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   empty,
   input  wire  [4*CB+lsg_pkg::DIR_BITS:0] head,
   output logic                  pop,
   input  wire  [lsg_pkg::DIST_BITS-1:0]  distance_limit,
   input  wire  [lsg_pkg::ANGLE_BITS-1:0] angle_limit,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [CB-1:0]         rsp_mean_start_x,
   output logic [CB-1:0]         rsp_mean_start_y,
   output logic [CB-1:0]         rsp_mean_end_x,
   output logic [CB-1:0]         rsp_mean_end_y,
   output logic                  rsp_group_last,
   output logic                  rsp_table_overflowed
);
   localparam int CW  = $clog2(MAX_LINES + 1);
   localparam int SW  = CB + CW;
   localparam int EW  = 4 * SW + CW;
   localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int NW  = $clog2(MAX_GROUPS + 1);
   localparam int QW  = (2 * CB + 3 > 24) ? 2 * CB + 3 : 24;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_START = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_ANG   = 4'd4;
   localparam logic [3:0] S_NEWG  = 4'd5;
   localparam logic [3:0] S_FIN   = 4'd6;
   localparam logic [3:0] S_EREAD = 4'd7;
   localparam logic [3:0] S_ESTRT = 4'd8;
   localparam logic [3:0] S_EWAIT = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [NW-1:0]     g_ff, g_in, gin_ff, gin_in;
   logic              drop_ff, drop_in;
   logic [4*CB:0]     seg_ff, seg_in;
   lsg_pkg::dir_type  sdir_ff, sdir_in;
   logic [EW-1:0]     mem_ff [MAX_GROUPS];
   logic [EW-1:0]     rd_ff, wdata;
   logic [GW-1:0]     waddr;
   logic              we;
   logic [QW-1:0]     sq_ff, sq_in, lim_sq_ff;
   logic              out_v_ff, out_v_in;
   logic [4*CB+1:0]   out_ff, out_in;

   logic [CB-1:0]     sx, sy, ex, ey;
   logic              slast;
   logic [SW-1:0]     r_sx, r_sy, r_ex, r_ey;
   logic [CW-1:0]     r_cnt, den;
   logic              dstart, cstart;
   logic [3:0]        dbusy;
   logic [SW-1:0]     q0, q1, q2, q3;
   logic              cbusy;
   lsg_pkg::dir_type  gdir;
   logic signed [CB:0] ddx, ddy, cdx, cdy;
   logic signed [2*CB+1:0] px, py;
   logic signed [lsg_pkg::DIFF_BITS-1:0] dd, dd_abs, dd_w;
   logic              match, out_free;

   assign {sx, sy, ex, ey, slast} = seg_ff;
   assign {r_sx, r_sy, r_ex, r_ey, r_cnt} = rd_ff;
   assign den = (r_cnt == '0) ? CW'(1) : r_cnt;

   lsg_div #(.NW(SW), .DW(CW)) u_div0 (.clock(clock), .reset(reset), .start(dstart),
      .num(r_sx), .den(den), .busy(dbusy[0]), .quo(q0));
   lsg_div #(.NW(SW), .DW(CW)) u_div1 (.clock(clock), .reset(reset), .start(dstart),
      .num(r_sy), .den(den), .busy(dbusy[1]), .quo(q1));
   lsg_div #(.NW(SW), .DW(CW)) u_div2 (.clock(clock), .reset(reset), .start(dstart),
      .num(r_ex), .den(den), .busy(dbusy[2]), .quo(q2));
   lsg_div #(.NW(SW), .DW(CW)) u_div3 (.clock(clock), .reset(reset), .start(dstart),
      .num(r_ey), .den(den), .busy(dbusy[3]), .quo(q3));

   assign cdx = $signed({1'b0, q2[CB-1:0]}) - $signed({1'b0, q0[CB-1:0]});
   assign cdy = $signed({1'b0, q3[CB-1:0]}) - $signed({1'b0, q1[CB-1:0]});

   lsg_cordic #(.CB(CB)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart), .dx(cdx), .dy(cdy),
      .busy(cbusy), .angle(gdir)
   );

   assign ddx = $signed({1'b0, sx}) - $signed({1'b0, q0[CB-1:0]});
   assign ddy = $signed({1'b0, sy}) - $signed({1'b0, q1[CB-1:0]});
   assign px  = ddx * ddx;
   assign py  = ddy * ddy;

   always_comb begin
      dd     = lsg_pkg::DIFF_BITS'(sdir_ff) - lsg_pkg::DIFF_BITS'(gdir);
      dd_abs = (dd < 0) ? -dd : dd;
      dd_w   = lsg_pkg::DIFF_BITS'(lsg_pkg::DEG_360) - dd_abs;
      if (dd_abs > lsg_pkg::DIFF_BITS'(lsg_pkg::DEG_180)) begin
         dd_abs = (dd_w < 0) ? -dd_w : dd_w;
      end
      match = (sq_ff <= lim_sq_ff) &&
              (dd_abs <= $signed({{(lsg_pkg::DIFF_BITS-lsg_pkg::ANGLE_BITS-8){1'b0}},
                                  angle_limit, 8'd0}));
   end

   assign out_free = !out_v_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      g_in     = g_ff;
      gin_in   = gin_ff;
      drop_in  = drop_ff;
      seg_in   = seg_ff;
      sdir_in  = sdir_ff;
      sq_in    = sq_ff;
      out_in   = out_ff;
      out_v_in = out_v_ff && rsp_stall;
      pop      = 1'b0;
      dstart   = 1'b0;
      cstart   = 1'b0;
      we       = 1'b0;
      waddr    = g_ff[GW-1:0];
      wdata    = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               {seg_in, sdir_in} = head;
               g_in     = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = (g_ff < gin_ff) ? S_START : S_NEWG;
         end
         S_START: begin
            dstart   = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (dbusy == 4'd0) begin
               cstart   = 1'b1;
               sq_in    = QW'(px[2*CB+1:0]) + QW'(py[2*CB+1:0]);
               state_in = S_ANG;
            end
         end
         S_ANG: begin
            if (!cbusy) begin
               if (match) begin
                  if (r_cnt < CW'(MAX_LINES)) begin
                     we    = 1'b1;
                     wdata = {r_sx + SW'(sx), r_sy + SW'(sy), r_ex + SW'(ex),
                              r_ey + SW'(ey), r_cnt + CW'(1)};
                  end
                  state_in = S_FIN;
               end else begin
                  g_in     = g_ff + NW'(1);
                  state_in = S_CHECK;
               end
            end
         end
         S_NEWG: begin
            if (gin_ff < NW'(MAX_GROUPS)) begin
               we     = 1'b1;
               waddr  = gin_ff[GW-1:0];
               wdata  = {SW'(sx), SW'(sy), SW'(ex), SW'(ey), CW'(1)};
               gin_in = gin_ff + NW'(1);
            end else begin
               drop_in = 1'b1;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            g_in = '0;
            if (!slast) begin
               state_in = S_IDLE;
            end else if (gin_ff == '0) begin
               drop_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_EREAD;
            end
         end
         S_EREAD: begin
            state_in = S_ESTRT;
         end
         S_ESTRT: begin
            dstart   = 1'b1;
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (dbusy == 4'd0 && out_free) begin
               out_v_in = 1'b1;
               out_in   = {q0[CB-1:0], q1[CB-1:0], q2[CB-1:0], q3[CB-1:0],
                           g_ff + NW'(1) == gin_ff, drop_ff};
               if (g_ff + NW'(1) == gin_ff) begin
                  gin_in   = '0;
                  drop_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  g_in     = g_ff + NW'(1);
                  state_in = S_EREAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gin_ff   <= '0;
         drop_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gin_ff   <= gin_in;
         drop_ff  <= drop_in;
         out_v_ff <= out_v_in;
      end
      g_ff      <= g_in;
      seg_ff    <= seg_in;
      sdir_ff   <= sdir_in;
      sq_ff     <= sq_in;
      out_ff    <= out_in;
      lim_sq_ff <= QW'(distance_limit) * QW'(distance_limit);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[g_ff[GW-1:0]];
   end

   assign rsp_valid = out_v_ff;
   assign {rsp_mean_start_x, rsp_mean_start_y, rsp_mean_end_x, rsp_mean_end_y,
           rsp_group_last, rsp_table_overflowed} = out_ff;

   a_gin_bound: assert property (@(posedge clock) disable iff (reset)
      gin_ff <= NW'(MAX_GROUPS)) else $error("group count above table size");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      $rose(drop_ff) |-> gin_ff == NW'(MAX_GROUPS)) else $error("drop with free entry");
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(state_ff) == S_EWAIT) else $error("result outside emit");
   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EWAIT && state_in == S_IDLE) |=> gin_ff == '0 && !drop_ff)
      else $error("groups not cleared after frame");
endmodule
`default_nettype wire

### hdl/line_segment_grouper.sv
// Each segment's direction is found by the front CORDIC; the back then walks the open
// groups one by one, running its four dividers and then its CORDIC for each group.
// The back handles one segment at a time; a four-entry FIFO lets the front take the next.
// A frame's last segment then emits one result per group, in table order.
// Reset (synchronous, active high) clears all groups, the overflow flag and restores limits.
`default_nettype none
module line_segment_grouper #(
   parameter int MAX_GROUPS = 16,
   parameter int MAX_LINES  = 1024,
   parameter int COORD_BITS = 12
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [COORD_BITS-1:0] req_start_x,
   input  wire  [COORD_BITS-1:0] req_start_y,
   input  wire  [COORD_BITS-1:0] req_end_x,
   input  wire  [COORD_BITS-1:0] req_end_y,
   input  wire                   req_frame_last,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [COORD_BITS-1:0] rsp_mean_start_x,
   output logic [COORD_BITS-1:0] rsp_mean_start_y,
   output logic [COORD_BITS-1:0] rsp_mean_end_x,
   output logic [COORD_BITS-1:0] rsp_mean_end_y,
   output logic                  rsp_group_last,
   output logic                  rsp_table_overflowed,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [2:0]            paddr,
   input  wire  [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   localparam int QDW = 4 * COORD_BITS + lsg_pkg::DIR_BITS + 1;

   logic [lsg_pkg::DIST_BITS-1:0]  dist_ff;
   logic [lsg_pkg::ANGLE_BITS-1:0] ang_ff;
   logic            push, full, pop, empty;
   logic [QDW-1:0]  push_data, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= lsg_pkg::DIST_BITS'(40);
         ang_ff  <= lsg_pkg::ANGLE_BITS'(30);
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == lsg_pkg::REG_DISTANCE) begin
            dist_ff <= pwdata[lsg_pkg::DIST_BITS-1:0];
         end else begin
            ang_ff <= pwdata[lsg_pkg::ANGLE_BITS-1:0];
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == lsg_pkg::REG_ANGLE) ? 32'(ang_ff) : 32'(dist_ff);

   lsg_front #(.CB(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_end_x(req_end_x),
      .req_end_y(req_end_y), .req_frame_last(req_frame_last),
      .push(push), .push_data(push_data), .full(full)
   );

   lsg_fifo #(.W(QDW)) u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .full(full),
      .pop(pop), .head(head), .empty(empty)
   );

   lsg_back #(.MAX_GROUPS(MAX_GROUPS), .MAX_LINES(MAX_LINES), .CB(COORD_BITS)) u_back (
      .clock(clock), .reset(reset), .empty(empty), .head(head), .pop(pop),
      .distance_limit(dist_ff), .angle_limit(ang_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_mean_start_x(rsp_mean_start_x), .rsp_mean_start_y(rsp_mean_start_y),
      .rsp_mean_end_x(rsp_mean_end_x), .rsp_mean_end_y(rsp_mean_end_y),
      .rsp_group_last(rsp_group_last), .rsp_table_overflowed(rsp_table_overflowed)
   );
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
module testbench;

   localparam int GROUP_SLOTS = 16;
   localparam int LINE_BOUND  = 1024;
   localparam int COORD_MAX   = 4095;
   localparam int QUIET_WAIT  = 1200;

   typedef struct {
      logic [11:0] sx, sy, ex, ey;
      logic        last;
   } segment_type;

   typedef struct packed {
      logic [11:0] sx, sy, ex, ey;
      logic        group_last;
      logic        overflowed;
   } group_mean_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [11:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic        req_frame_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_mean_start_x, rsp_mean_start_y, rsp_mean_end_x, rsp_mean_end_y;
   logic        rsp_group_last, rsp_table_overflowed;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        hold_off = 1'b0;

   segment_type    pending_segments[$];
   group_mean_type expected_means[$];
   segment_type    on_bus;
   int          send_wait = 0, calm_left = 0, stall_left = 0;
   int          mismatches = 0, segments_sent = 0, means_seen = 0, overflow_seen = 0;

   longint      grp_sx[GROUP_SLOTS], grp_sy[GROUP_SLOTS], grp_ex[GROUP_SLOTS], grp_ey[GROUP_SLOTS];
   int          grp_count[GROUP_SLOTS];
   int          grp_used = 0;
   bit          grp_dropped = 0;
   longint      dist_lim = 40, ang_lim = 30;

   line_segment_grouper uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_frame_last(req_frame_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_mean_start_x(rsp_mean_start_x), .rsp_mean_start_y(rsp_mean_start_y),
      .rsp_mean_end_x(rsp_mean_end_x), .rsp_mean_end_y(rsp_mean_end_y),
      .rsp_group_last(rsp_group_last), .rsp_table_overflowed(rsp_table_overflowed),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic longint heading(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = lsg_pkg::DEG_90;
         end else begin
            x = -y; y = t; z = -lsg_pkg::DEG_90;
         end
      end
      for (int i = 0; i < lsg_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += longint'(lsg_pkg::atan_step(i[3:0]));
         end else begin
            x -= ys; y += xs; z -= longint'(lsg_pkg::atan_step(i[3:0]));
         end
      end
      return z;
   endfunction

   task automatic group_segment(segment_type s);
      longint sx, sy, ex, ey, dir, ax, ay, bx, by, c, d;
      bit joined;
      group_mean_type m;
      sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
      dir = heading(ex - sx, ey - sy);
      joined = 0;
      for (int g = 0; g < grp_used && !joined; g++) begin
         c = grp_count[g];
         ax = grp_sx[g] / c; ay = grp_sy[g] / c;
         bx = grp_ex[g] / c; by = grp_ey[g] / c;
         d = dir - heading(bx - ax, by - ay);
         if (d < 0) d = -d;
         if (d > lsg_pkg::DEG_180) begin
            d = lsg_pkg::DEG_360 - d;
            if (d < 0) d = -d;
         end
         if ((sx-ax)*(sx-ax) + (sy-ay)*(sy-ay) <= dist_lim*dist_lim && d <= ang_lim*256) begin
            if (grp_count[g] < LINE_BOUND) begin
               grp_sx[g] += sx; grp_sy[g] += sy; grp_ex[g] += ex; grp_ey[g] += ey;
               grp_count[g]++;
            end
            joined = 1;
         end
      end
      if (!joined) begin
         if (grp_used < GROUP_SLOTS) begin
            grp_sx[grp_used] = sx; grp_sy[grp_used] = sy;
            grp_ex[grp_used] = ex; grp_ey[grp_used] = ey;
            grp_count[grp_used] = 1;
            grp_used++;
         end else grp_dropped = 1;
      end
      if (s.last) begin
         for (int g = 0; g < grp_used; g++) begin
            c = grp_count[g];
            m.sx = 12'(grp_sx[g] / c); m.sy = 12'(grp_sy[g] / c);
            m.ex = 12'(grp_ex[g] / c); m.ey = 12'(grp_ey[g] / c);
            m.group_last = (g + 1 == grp_used);
            m.overflowed = grp_dropped;
            expected_means.insert(expected_means.size(), m);
         end
         grp_used = 0;
         grp_dropped = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            group_segment(on_bus);
            segments_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_segments.size() > 0) begin
               on_bus = pending_segments.pop_front();
               req_start_x <= on_bus.sx;
               req_start_y <= on_bus.sy;
               req_end_x <= on_bus.ex;
               req_end_y <= on_bus.ey;
               req_frame_last <= on_bus.last;
               req_valid <= 1'b1;
               if (calm_left > 0) begin
                  calm_left--;
                  send_wait = 0;
               end else if ($urandom_range(0, 30) == 0) begin
                  calm_left = 40;
                  send_wait = 0;
               end else send_wait = $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      group_mean_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_mean_start_x, rsp_mean_start_y, rsp_mean_end_x, rsp_mean_end_y,
                   rsp_group_last, rsp_table_overflowed};
            means_seen++;
            if (rsp_table_overflowed) overflow_seen++;
            if (expected_means.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected group mean %p", got);
            end else begin
               want = expected_means.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
               end
            end
            stall_left = (calm_left > 0) ? 0 : $urandom_range(0, 6);
         end
         rsp_stall <= hold_off || stall_left > 0;
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic csr_write(logic idx, int value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == lsg_pkg::REG_DISTANCE) dist_lim = value & 12'hFFF;
      else ang_lim = value & 8'hFF;
   endtask

   task automatic drain;
      while (pending_segments.size() > 0 || req_valid || expected_means.size() > 0)
         @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   function automatic logic [11:0] clamp(int v);
      return (v < 0) ? 12'd0 : (v > COORD_MAX) ? 12'd4095 : 12'(v);
   endfunction

   task automatic add(int sx, int sy, int ex, int ey, bit last);
      segment_type s;
      s.sx = 12'(sx); s.sy = 12'(sy); s.ex = 12'(ex); s.ey = 12'(ey); s.last = last;
      pending_segments.insert(pending_segments.size(), s);
   endtask

   task automatic add_frames(int target);
      int n, k, pick, cx[5], cy[5], vx[5], vy[5], sx, sy, jit;
      bit noise;
      for (int done = 0; done < target; done += n) begin
         n = $urandom_range(1, 25);
         k = $urandom_range(1, 5);
         noise = ($urandom_range(0, 5) == 0);
         jit = $urandom_range(0, 30);
         for (int c = 0; c < k; c++) begin
            cx[c] = $urandom_range(0, COORD_MAX); cy[c] = $urandom_range(0, COORD_MAX);
            vx[c] = $urandom_range(0, 800) - 400; vy[c] = $urandom_range(0, 800) - 400;
         end
         for (int i = 0; i < n; i++) begin
            if (noise) begin
               add($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), i == n - 1);
            end else begin
               pick = $urandom_range(0, k - 1);
               sx = cx[pick] + $urandom_range(0, 2*jit) - jit;
               sy = cy[pick] + $urandom_range(0, 2*jit) - jit;
               add(clamp(sx), clamp(sy),
                   clamp(sx + vx[pick] + $urandom_range(0, 2*jit) - jit),
                   clamp(sy + vy[pick] + $urandom_range(0, 2*jit) - jit), i == n - 1);
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add(0, 0, 0, 0, 1);
      add(4095, 4095, 0, 0, 0);
      add(0, 0, 4095, 4095, 0);
      add(100, 100, 100, 900, 0);
      add(100, 100, 100, 0, 0);
      add(2000, 2000, 1000, 2000, 0);
      add(2000, 2000, 1000, 1990, 0);
      add(2000, 2000, 1000, 2010, 0);
      add(3000, 50, 2000, 0, 0);
      add(3000, 50, 2000, 4095, 0);
      add(4095, 0, 0, 4095, 1);
      for (int i = 0; i < 18; i++)
         add(i * 230, 4095 - i * 200, i * 100, 17 * i, i == 17);
      add(500, 500, 500, 500, 1);
      add_frames(45);
      drain();

      csr_write(lsg_pkg::REG_DISTANCE, 4095);
      csr_write(lsg_pkg::REG_ANGLE, 255);
      for (int i = 0; i < 40; i++)
         add($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
             $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), i == 39);
      add_frames(20);
      drain();

      csr_write(lsg_pkg::REG_DISTANCE, 0);
      csr_write(lsg_pkg::REG_ANGLE, 0);
      add(7, 7, 70, 70, 0);
      add(7, 7, 70, 70, 1);
      add_frames(30);
      drain();

      csr_write(lsg_pkg::REG_DISTANCE, 200);
      csr_write(lsg_pkg::REG_ANGLE, 180);
      add_frames(30);
      drain();

      csr_write(lsg_pkg::REG_DISTANCE, 15);
      csr_write(lsg_pkg::REG_ANGLE, 10);
      add_frames(30);
      drain();

      csr_write(lsg_pkg::REG_DISTANCE, 4095);
      csr_write(lsg_pkg::REG_ANGLE, 0);
      add_frames(25);
      drain();

      csr_write(lsg_pkg::REG_DISTANCE, 60);
      csr_write(lsg_pkg::REG_ANGLE, 181);
      add_frames(25);
      drain();

      $display("covered %0d segments and %0d group means, %0d of them flagged overflow",
               segments_sent, means_seen, overflow_seen);
      $display("limits swept through both extremes, full tables and a long receiver hold-off");
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      wait (segments_sent >= 100 && pending_segments.size() > 20);
      hold_off <= 1'b1;
      repeat (6000) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### line_segment_grouper.f
hdl/lsg_pkg.sv
hdl/lsg_cordic.sv
hdl/lsg_div.sv
hdl/lsg_fifo.sv
hdl/lsg_front.sv
hdl/lsg_back.sv
hdl/line_segment_grouper.sv
tb/testbench.sv
